FILE: rtl/gcr_8b9b_encoder_defines.svh
// Assertion macros for the GCR 8b/9b encoder.
// Used by gcr_8b9b_encoder.sv; needs a signal named clk and a signal named rst in scope.
`ifndef GCR_8B9B_ENCODER_DEFINES_SVH
`define GCR_8B9B_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gcr encoder assertion failed");
`define GCR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gcr encoder assertion failed");
`else
`define GCR_ASSERT(lbl, prop)
`define GCR_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/gcr89_pkg.sv
// Package for the GCR 8b/9b encoder: code table, widths and packer types.
// No dependencies; imported by gcr89_packer and gcr_8b9b_encoder.
package gcr89_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 9;
  localparam int unsigned LeftW = 7;
  localparam int unsigned PosW  = 3;
  localparam int unsigned AccW  = LeftW + WordW;

  localparam logic [WordW-1:0] WordMask = 9'h1ff;
  localparam logic [PosW-1:0]  LastPos  = 3'd7;

  localparam logic [WordW-1:0] CodeTable [0:255] = '{
    9'd124, 9'd125, 9'd120, 9'd121, 9'd123, 9'd113, 9'd115, 9'd114,
    9'd119, 9'd118, 9'd116, 9'd97,  9'd99,  9'd98,  9'd103, 9'd102,
    9'd100, 9'd110, 9'd108, 9'd109, 9'd104, 9'd105, 9'd107, 9'd65,
    9'd67,  9'd66,  9'd71,  9'd70,  9'd68,  9'd78,  9'd76,  9'd77,
    9'd72,  9'd73,  9'd75,  9'd94,  9'd92,  9'd93,  9'd88,  9'd89,
    9'd91,  9'd81,  9'd83,  9'd82,  9'd248, 9'd249, 9'd251, 9'd241,
    9'd243, 9'd242, 9'd247, 9'd246, 9'd244, 9'd225, 9'd227, 9'd226,
    9'd231, 9'd230, 9'd228, 9'd238, 9'd236, 9'd237, 9'd232, 9'd233,
    9'd235, 9'd193, 9'd195, 9'd194, 9'd199, 9'd198, 9'd196, 9'd206,
    9'd204, 9'd205, 9'd200, 9'd201, 9'd203, 9'd222, 9'd220, 9'd221,
    9'd216, 9'd217, 9'd219, 9'd209, 9'd211, 9'd210, 9'd215, 9'd214,
    9'd131, 9'd130, 9'd135, 9'd134, 9'd132, 9'd142, 9'd140, 9'd141,
    9'd136, 9'd137, 9'd139, 9'd158, 9'd156, 9'd157, 9'd152, 9'd153,
    9'd155, 9'd145, 9'd147, 9'd146, 9'd151, 9'd150, 9'd148, 9'd190,
    9'd188, 9'd189, 9'd184, 9'd185, 9'd187, 9'd177, 9'd179, 9'd178,
    9'd183, 9'd182, 9'd180, 9'd161, 9'd163, 9'd162, 9'd167, 9'd166,
    9'd164, 9'd497, 9'd499, 9'd498, 9'd503, 9'd502, 9'd500, 9'd481,
    9'd483, 9'd482, 9'd487, 9'd486, 9'd484, 9'd494, 9'd492, 9'd493,
    9'd488, 9'd489, 9'd491, 9'd449, 9'd451, 9'd450, 9'd455, 9'd454,
    9'd452, 9'd462, 9'd460, 9'd461, 9'd456, 9'd457, 9'd459, 9'd478,
    9'd476, 9'd477, 9'd472, 9'd473, 9'd475, 9'd465, 9'd467, 9'd466,
    9'd471, 9'd470, 9'd387, 9'd386, 9'd391, 9'd390, 9'd388, 9'd398,
    9'd396, 9'd397, 9'd392, 9'd393, 9'd395, 9'd414, 9'd412, 9'd413,
    9'd408, 9'd409, 9'd411, 9'd401, 9'd403, 9'd402, 9'd407, 9'd406,
    9'd404, 9'd446, 9'd444, 9'd445, 9'd440, 9'd441, 9'd443, 9'd433,
    9'd435, 9'd434, 9'd439, 9'd438, 9'd436, 9'd417, 9'd419, 9'd418,
    9'd423, 9'd422, 9'd420, 9'd430, 9'd428, 9'd429, 9'd263, 9'd262,
    9'd260, 9'd270, 9'd268, 9'd269, 9'd264, 9'd265, 9'd267, 9'd286,
    9'd284, 9'd285, 9'd280, 9'd281, 9'd283, 9'd273, 9'd275, 9'd274,
    9'd279, 9'd278, 9'd276, 9'd318, 9'd316, 9'd317, 9'd312, 9'd313,
    9'd315, 9'd305, 9'd307, 9'd306, 9'd311, 9'd310, 9'd308, 9'd289,
    9'd291, 9'd290, 9'd295, 9'd294, 9'd292, 9'd302, 9'd300, 9'd301
  };

  typedef struct packed {
    logic             polarity_bit;
    logic [LeftW-1:0] leftover_bits;
    logic [PosW-1:0]  group_position;
  } gcr_state_t;

  typedef struct packed {
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic             two;
    gcr_state_t       state_next;
  } gcr_result_t;

endpackage

FILE: rtl/gcr_8b9b_encoder.sv
// Top level of the GCR 8b/9b encoder: input handshake, coder state, two-byte output buffer.
// Depends on gcr89_pkg, gcr89_packer and gcr_8b9b_encoder_defines.svh.
//
// Usage:
//   Slave channel s_* carries one raw data byte per transfer. Master channel m_* carries
//   packed code bytes, most significant bit sent first; m_tlast marks the final byte that
//   an input byte causes. Inputs one to seven of a group of eight give one byte each, the
//   eighth gives two, so eight inputs yield nine output bytes.
// The first output byte of an input transfer is valid in the cycle after the transfer.
// Throughput: one input per cycle while m_tready stays high and each input causes one byte;
//   the eighth of a group holds the input side while its first byte drains, since the
//   byte-wide master channel carries one byte per transfer.
// The output buffer holds up to two bytes; a new input is taken when it is empty, or in
//   the cycle its single remaining byte is taken.
// Stall: with m_tready low the buffered bytes hold and s_tready drops once the buffer is
//   occupied and cannot drain.
// Reset (rst, synchronous): polarity, leftover bits and group position clear, buffer
//   empties. Bits of an unfinished group are never flushed.
`include "gcr_8b9b_encoder_defines.svh"

module gcr_8b9b_encoder
  import gcr89_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ByteW-1:0] s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [ByteW-1:0] m_tdata,   // [7:0] out_byte
  output logic             m_tlast
);

  gcr_state_t       state;
  gcr_result_t      result;
  logic [1:0]       cnt;
  logic [ByteW-1:0] slot0;
  logic [ByteW-1:0] slot1;
  logic             in_fire;
  logic             out_fire;

  gcr89_packer u_packer (
    .data_byte (s_tdata),
    .state     (state),
    .result    (result)
  );

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = slot0;
  assign m_tlast  = (cnt == 2'd1);
  assign s_tready = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      cnt   <= 2'd0;
    end else if (in_fire) begin
      state <= result.state_next;
      cnt   <= result.two ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      cnt   <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot0 <= result.two ? result.byte0 : result.byte0;
      slot1 <= result.byte1;
    end else if (out_fire && (cnt == 2'd2)) begin
      slot0 <= slot1;
    end
  end

  `GCR_ASSERT(a_no_take_when_full, s_tready |-> (cnt != 2'd2))
  `GCR_ASSERT(a_eighth_gives_two,
    (in_fire && (state.group_position == LastPos)) |=> (cnt == 2'd2))
  `GCR_ASSERT(a_first_of_two_not_last, (m_tvalid && !m_tlast) |-> (cnt == 2'd2))
  `GCR_ASSERT(a_position_advances,
    (in_fire && (state.group_position != LastPos))
      |=> (state.group_position == $past(state.group_position) + 3'd1))
  `GCR_ASSERT(a_stale_bits_clear,
    ((state.leftover_bits >> state.group_position) == 7'd0))
  `GCR_ASSERT_RST(a_reset_empties, rst |=> !m_tvalid)

endmodule

FILE: rtl/gcr89_packer.sv
// Code lookup, polarity inversion and MSB-first packing for one input byte.
// Combinational; depends on gcr89_pkg.
module gcr89_packer
  import gcr89_pkg::*;
(
  input  logic [ByteW-1:0] data_byte,
  input  gcr_state_t       state,
  output gcr_result_t      result
);

  logic [WordW-1:0] word;
  logic [LeftW-1:0] left;
  logic [AccW-1:0]  acc;
  logic [PosW:0]    shamt;
  logic [AccW-1:0]  keep_mask;

  always_comb begin
    word      = CodeTable[data_byte] ^ (state.polarity_bit ? WordMask : '0);
    left      = state.leftover_bits & LeftW'((8'd1 << state.group_position) - 8'd1);
    acc       = {left, word};
    shamt     = {1'b0, state.group_position} + 4'd1;
    keep_mask = (AccW'(1) << shamt) - AccW'(1);

    result.byte0                     = ByteW'(acc >> shamt);
    result.byte1                     = acc[ByteW-1:0];
    result.two                       = (state.group_position == LastPos);
    result.state_next.polarity_bit   = word[0];
    if (result.two) begin
      result.state_next.leftover_bits  = '0;
      result.state_next.group_position = '0;
    end else begin
      result.state_next.leftover_bits  = LeftW'(acc & keep_mask);
      result.state_next.group_position = state.group_position + 3'd1;
    end
  end

endmodule

FILE: test/gcr_8b9b_encoder_test.sv
// Self-checking bench for gcr_8b9b_encoder: random bursts of data bytes in, packed code bytes out.
// Holds its own encoder with polarity, leftover bits and group slot; uses gcr89_pkg for the table.
// Needs only the RTL: gcr89_pkg, gcr89_packer and gcr_8b9b_encoder.
module gcr_8b9b_encoder_test;
  import gcr89_pkg::*;

  typedef struct {
    logic [ByteW-1:0] data;
    bit               drain_first;
  } feed_item_t;

  typedef struct {
    logic [ByteW-1:0] code_byte;
    logic             last;
  } coded_byte_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [ByteW-1:0] s_tdata = '0;   // [7:0] data_byte
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [ByteW-1:0] m_tdata;        // [7:0] out_byte
  logic             m_tlast;

  feed_item_t  feed_q[$];
  coded_byte_t coded_due[$];

  logic             line_polarity = 1'b0;
  logic [LeftW-1:0] carry_bits = '0;
  logic [PosW-1:0]  group_slot = '0;

  int         burst_left = 1;
  int         gap_left = 0;
  int         mismatch_count = 0;
  logic [7:0] stall_tick = '0;

  gcr_8b9b_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  task automatic predict_bytes(input logic [ByteW-1:0] data);
    logic [WordW-1:0] word;
    logic [15:0]      kept;
    logic [15:0]      acc;
    logic [15:0]      first;
    word = CodeTable[data];
    if (line_polarity) begin
      word = word ^ WordMask;
    end
    line_polarity = word[0];
    kept = 16'(carry_bits) & ((16'd1 << group_slot) - 16'd1);
    acc = (kept << WordW) | 16'(word);
    if (group_slot == LastPos) begin
      coded_due.push_back('{code_byte: acc[15:8], last: 1'b0});
      coded_due.push_back('{code_byte: acc[7:0], last: 1'b1});
      carry_bits = '0;
      group_slot = '0;
    end else begin
      first = acc >> (group_slot + 1);
      coded_due.push_back('{code_byte: first[7:0], last: 1'b1});
      carry_bits = LeftW'(acc & ((16'd1 << (group_slot + 1)) - 16'd1));
      group_slot = group_slot + 1'b1;
    end
  endtask

  // Sender: bursts of transfers separated by random gaps; a drain_first item waits for the expected bytes to drain
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_bytes(s_tdata);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (feed_q.size() == 0 ||
                     (feed_q[0].drain_first && coded_due.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tdata  <= feed_q[0].data;
          s_tvalid <= 1'b1;
          feed_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Receiver: cycle through always-ready, random, sparse and long-stall stretches
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[7:6])
      2'd0: begin
        m_tready <= 1'b1;
      end
      2'd1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        m_tready <= (stall_tick[1:0] == 2'd0);
      end
      default: begin
        m_tready <= (stall_tick[4:3] == 2'd0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (coded_due.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual out_byte %02h last %0b",
                 $time, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        if (m_tdata !== coded_due[0].code_byte) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, coded_due[0].code_byte, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== coded_due[0].last) begin
          $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                   $time, coded_due[0].last, m_tlast);
          mismatch_count++;
        end
        coded_due.pop_front();
      end
    end
  end

  initial begin
    logic [ByteW-1:0] directed[$];
    directed = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'h55, 8'haa,
                 8'h01, 8'h01, 8'h00, 8'hff, 8'hff, 8'h17, 8'hfe, 8'hff,
                 8'h2c, 8'h80, 8'h81};
    foreach (directed[i]) begin
      feed_q.push_back('{data: directed[i], drain_first: 1'b0});
    end
    // hold the random part, and every 160th random byte, until the earlier results have drained
    for (int i = 0; i < 650; i++) begin
      feed_q.push_back('{data: ByteW'($urandom_range(0, 255)),
                         drain_first: (i % 160 == 0)});
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (feed_q.size() != 0 || s_tvalid || coded_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gcr89_pkg.sv
rtl/gcr89_packer.sv
rtl/gcr_8b9b_encoder.sv
test/gcr_8b9b_encoder_test.sv
